// ===== hdl/eight_bit_cpu_alu_with_flags_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the 8-bit CPU ALU
// Concurrent check helpers, same-cycle and next-cycle forms.
// ----------------------------------------------------------------------------
`ifndef EIGHT_BIT_CPU_ALU_WITH_FLAGS_MACROS_SVH
`define EIGHT_BIT_CPU_ALU_WITH_FLAGS_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CPUALU_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpualu assertion failed");

// antecedent implies consequent in the next cycle
`define CPUALU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpualu assertion failed");

`endif

// ===== hdl/cpualu_pkg.sv =====
// ----------------------------------------------------------------------------
// cpualu_pkg
// Types, operation codes and helpers shared by the ALU files.
// ----------------------------------------------------------------------------
package cpualu_pkg;

  typedef enum logic [4:0] {
    MODE_INC   = 5'd0,
    MODE_DEC   = 5'd1,
    MODE_ADD   = 5'd2,
    MODE_SUB   = 5'd3,
    MODE_CP    = 5'd4,
    MODE_AND   = 5'd5,
    MODE_XOR   = 5'd6,
    MODE_OR    = 5'd7,
    MODE_RLC   = 5'd8,
    MODE_RL    = 5'd9,
    MODE_RRC   = 5'd10,
    MODE_RR    = 5'd11,
    MODE_SLA   = 5'd12,
    MODE_SLL   = 5'd13,
    MODE_SRA   = 5'd14,
    MODE_SRL   = 5'd15,
    MODE_BIT   = 5'd16,
    MODE_RES   = 5'd17,
    MODE_SET   = 5'd18,
    MODE_ADD16 = 5'd19,
    MODE_ADC16 = 5'd20,
    MODE_SBC16 = 5'd21
  } mode_t;

  typedef struct packed {
    logic s;
    logic z;
    logic h;
    logic pv;
    logic n;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [4:0]  mode;
    logic [7:0]  operand;
    logic        carry_in;
    logic [2:0]  bit_index;
    logic [15:0] wide_source;
    logic [15:0] wide_dest;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result;
    logic [7:0]  accumulator;
    flags_t      flags;
  } out_item_t;

  localparam logic [7:0] BYTE_MAX_POS = 8'h7F;
  localparam logic [7:0] BYTE_MIN_NEG = 8'h80;

  // even parity: 1 when the count of ones is even
  function automatic logic even_parity(input logic [7:0] v);
    even_parity = ~^v;
  endfunction

endpackage

// ===== hdl/cpualu_in_if.sv =====
// ----------------------------------------------------------------------------
// cpualu_in_if
// Request channel: one ALU operation per transfer.
// ----------------------------------------------------------------------------
interface cpualu_in_if;
  import cpualu_pkg::*;

  logic        valid;
  logic        ready;
  logic [4:0]  mode;
  logic [7:0]  operand;
  logic        carry_in;
  logic [2:0]  bit_index;
  logic [15:0] wide_source;
  logic [15:0] wide_dest;

  modport source (
    output valid, mode, operand, carry_in, bit_index, wide_source, wide_dest,
    input  ready
  );
  modport sink (
    input  valid, mode, operand, carry_in, bit_index, wide_source, wide_dest,
    output ready
  );
endinterface

// ===== hdl/cpualu_out_if.sv =====
// ----------------------------------------------------------------------------
// cpualu_out_if
// Result channel: result value, accumulator and flags.
// ----------------------------------------------------------------------------
interface cpualu_out_if;
  import cpualu_pkg::*;

  logic        valid;
  logic        ready;
  logic [15:0] result;
  logic [7:0]  accumulator_out;
  logic        flag_sign;
  logic        flag_zero;
  logic        flag_half;
  logic        flag_parity_overflow;
  logic        flag_subtract;
  logic        flag_carry;

  modport source (
    output valid, result, accumulator_out, flag_sign, flag_zero, flag_half,
           flag_parity_overflow, flag_subtract, flag_carry,
    input  ready
  );
  modport sink (
    input  valid, result, accumulator_out, flag_sign, flag_zero, flag_half,
           flag_parity_overflow, flag_subtract, flag_carry,
    output ready
  );
endinterface

// ===== hdl/eight_bit_cpu_alu_with_flags.sv =====
// ----------------------------------------------------------------------------
// eight_bit_cpu_alu_with_flags
// 8-bit CPU ALU with accumulator and S/Z/H/PV/N/C flags, two-stage pipe.
// ----------------------------------------------------------------------------
// One request enters per clock when the result side keeps up: a request
// is captured in the operation register, then worked out in one combinational
// pass against the live accumulator and flags in the next cycle, and written
// to the result register together with the updated state. The state is
// updated in the same edge that loads the result register, so the following
// request, one stage behind, already sees it; there is no forwarding path and
// no bubble between dependent operations. Sustained rate is one request per
// cycle, limited by the single ALU pass (8-bit and 16-bit adders and the
// result mux). When the result consumer stalls, the two registers fill and
// ready drops; nothing is lost or replayed. Accumulator and flags reset to
// zero. Undefined modes (22-31) return 0 and leave the state alone.
// ----------------------------------------------------------------------------
module eight_bit_cpu_alu_with_flags (
  input logic          clk,
  input logic          rst,
  cpualu_in_if.sink    op_chan,
  cpualu_out_if.source res_chan
);
  import cpualu_pkg::*;

  `include "eight_bit_cpu_alu_with_flags_macros.svh"

  // architectural state
  logic [7:0] accumulator;
  flags_t     flags;

  // operation register (stage 1)
  logic       op_valid;
  in_item_t   op_item;

  // result register (stage 2)
  logic       res_valid;
  out_item_t  res_item;

  out_item_t  outcome;
  logic       res_free;
  logic       op_move;
  logic       op_take;

  // stage 2 frees when empty or drained this cycle
  assign res_free = !res_valid || res_chan.ready;
  // stage 1 retires into stage 2; state commits at the same edge
  assign op_move  = op_valid && res_free;
  assign op_take  = op_chan.valid && op_chan.ready;

  assign op_chan.ready = !op_valid || res_free;

  cpualu_core u_core (
    .item        (op_item),
    .accumulator (accumulator),
    .flags       (flags),
    .outcome     (outcome)
  );

  // control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid    <= 1'b0;
      res_valid   <= 1'b0;
      accumulator <= 8'd0;
      flags       <= '0;
    end else begin
      if (op_chan.ready) begin
        op_valid <= op_chan.valid;
      end
      if (res_free) begin
        res_valid <= op_valid;
      end
      if (op_move) begin
        accumulator <= outcome.accumulator;
        flags       <= outcome.flags;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (op_take) begin
      op_item.mode        <= op_chan.mode;
      op_item.operand     <= op_chan.operand;
      op_item.carry_in    <= op_chan.carry_in;
      op_item.bit_index   <= op_chan.bit_index;
      op_item.wide_source <= op_chan.wide_source;
      op_item.wide_dest   <= op_chan.wide_dest;
    end
    if (op_move) begin
      res_item <= outcome;
    end
  end

  assign res_chan.valid                = res_valid;
  assign res_chan.result               = res_item.result;
  assign res_chan.accumulator_out      = res_item.accumulator;
  assign res_chan.flag_sign            = res_item.flags.s;
  assign res_chan.flag_zero            = res_item.flags.z;
  assign res_chan.flag_half            = res_item.flags.h;
  assign res_chan.flag_parity_overflow = res_item.flags.pv;
  assign res_chan.flag_subtract        = res_item.flags.n;
  assign res_chan.flag_carry           = res_item.flags.c;

  // state only moves when an operation retires
  `CPUALU_ASSERT_NEXT(a_acc_hold, clk, rst, !op_move, $stable(accumulator) && $stable(flags))
  // response carries the state committed with it
  `CPUALU_ASSERT_NEXT(a_resp_state, clk, rst, op_move, res_chan.accumulator_out == accumulator)
  // compare never writes the accumulator
  `CPUALU_ASSERT_NEXT(a_cp_keeps_acc, clk, rst, op_move && (op_item.mode == MODE_CP), $stable(accumulator))

endmodule

// ===== hdl/cpualu_core.sv =====
// ----------------------------------------------------------------------------
// cpualu_core
// Combinational datapath: one operation against the current accumulator/flags.
// ----------------------------------------------------------------------------
module cpualu_core (
  input  cpualu_pkg::in_item_t  item,
  input  logic [7:0]            accumulator,
  input  cpualu_pkg::flags_t    flags,
  output cpualu_pkg::out_item_t outcome
);
  import cpualu_pkg::*;

  logic [7:0]  a;
  logic [7:0]  op;
  logic        cc_sub;
  logic        cin16;
  logic [7:0]  inc_r;
  logic [7:0]  dec_r;
  logic [8:0]  add_sum;
  logic [4:0]  add_low;
  logic [8:0]  sub_diff;
  logic [4:0]  sub_low;
  logic [16:0] add16_sum;
  logic [12:0] add16_low;
  logic [16:0] sbc16_diff;
  logic [12:0] sbc16_low;
  logic [7:0]  bit_mask;
  logic [7:0]  r8;
  logic [15:0] r16;
  logic [7:0]  acc_next;
  flags_t      f;
  logic        new_c;
  mode_t       mode;

  assign a    = accumulator;
  assign op   = item.operand;
  assign mode = mode_t'(item.mode);

  // cp ignores the extra borrow; adc16 takes the stored carry
  assign cc_sub = (mode == MODE_SUB) ? item.carry_in : 1'b0;
  assign cin16  = (mode == MODE_ADC16) ? flags.c : 1'b0;

  assign inc_r    = op + 8'd1;
  assign dec_r    = op - 8'd1;
  assign add_sum  = {1'b0, a} + {1'b0, op} + {8'd0, item.carry_in};
  assign add_low  = {1'b0, a[3:0]} + {1'b0, op[3:0]} + {4'd0, item.carry_in};
  assign sub_diff = {1'b0, a} - {1'b0, op} - {8'd0, cc_sub};
  assign sub_low  = {1'b0, a[3:0]} - {1'b0, op[3:0]} - {4'd0, cc_sub};

  assign add16_sum  = {1'b0, item.wide_dest} + {1'b0, item.wide_source}
                      + {16'd0, cin16};
  assign add16_low  = {1'b0, item.wide_dest[11:0]} + {1'b0, item.wide_source[11:0]}
                      + {12'd0, cin16};
  // half borrow uses the stored carry flag
  assign sbc16_diff = {1'b0, item.wide_dest} - {1'b0, item.wide_source}
                      - {16'd0, flags.c};
  assign sbc16_low  = {1'b0, item.wide_dest[11:0]} - {1'b0, item.wide_source[11:0]}
                      - {12'd0, flags.c};

  assign bit_mask = 8'd1 << item.bit_index;

  always_comb begin
    f        = flags;
    acc_next = a;
    r8       = 8'd0;
    r16      = 16'd0;
    new_c    = 1'b0;
    case (mode)
      MODE_INC, MODE_DEC: begin
        r8   = (mode == MODE_INC) ? inc_r : dec_r;
        f.n  = (mode == MODE_DEC);
        f.pv = (mode == MODE_INC) ? (op == BYTE_MAX_POS) : (op == BYTE_MIN_NEG);
        f.h  = (mode == MODE_INC) ? (op[3:0] == 4'hF) : (op[3:0] == 4'h0);
        f.s  = r8[7];
        f.z  = (r8 == 8'd0);
        r16  = {8'd0, r8};
      end
      MODE_ADD: begin
        r8       = add_sum[7:0];
        f.c      = add_sum[8];
        f.n      = 1'b0;
        f.h      = add_low[4];
        f.pv     = (a[7] ^ r8[7]) & (op[7] ^ r8[7]);
        f.s      = r8[7];
        f.z      = (r8 == 8'd0);
        acc_next = r8;
        r16      = {8'd0, r8};
      end
      MODE_SUB, MODE_CP: begin
        r8   = sub_diff[7:0];
        f.c  = sub_diff[8];
        f.n  = 1'b1;
        f.h  = sub_low[4];
        f.pv = (a[7] ^ op[7]) & (a[7] ^ r8[7]);
        f.s  = r8[7];
        f.z  = (r8 == 8'd0);
        if (mode == MODE_SUB) begin
          acc_next = r8;
        end
        r16  = {8'd0, r8};
      end
      MODE_AND, MODE_XOR, MODE_OR: begin
        r8       = (mode == MODE_AND) ? (a & op) :
                   (mode == MODE_XOR) ? (a ^ op) : (a | op);
        f.h      = (mode == MODE_AND);
        f.c      = 1'b0;
        f.n      = 1'b0;
        f.pv     = even_parity(r8);
        f.s      = r8[7];
        f.z      = (r8 == 8'd0);
        acc_next = r8;
        r16      = {8'd0, r8};
      end
      MODE_RLC, MODE_RL, MODE_RRC, MODE_RR,
      MODE_SLA, MODE_SLL, MODE_SRA, MODE_SRL: begin
        case (mode)
          MODE_RLC: begin new_c = op[7]; r8 = {op[6:0], op[7]};    end
          MODE_RL:  begin new_c = op[7]; r8 = {op[6:0], flags.c};  end
          MODE_RRC: begin new_c = op[0]; r8 = {op[0], op[7:1]};    end
          MODE_RR:  begin new_c = op[0]; r8 = {flags.c, op[7:1]};  end
          MODE_SLA: begin new_c = op[7]; r8 = {op[6:0], 1'b0};     end
          MODE_SLL: begin new_c = op[7]; r8 = {op[6:0], 1'b1};     end
          MODE_SRA: begin new_c = op[0]; r8 = {op[7], op[7:1]};    end
          default:  begin new_c = op[0]; r8 = {1'b0, op[7:1]};     end
        endcase
        f.c  = new_c;
        f.n  = 1'b0;
        f.h  = 1'b0;
        f.pv = even_parity(r8);
        f.s  = r8[7];
        f.z  = (r8 == 8'd0);
        r16  = {8'd0, r8};
      end
      MODE_BIT: begin
        f.n = 1'b0;
        f.h = 1'b1;
        f.z = ~op[item.bit_index];
        r16 = {8'd0, op};
      end
      MODE_RES: begin
        r16 = {8'd0, op & ~bit_mask};
      end
      MODE_SET: begin
        r16 = {8'd0, op | bit_mask};
      end
      MODE_ADD16, MODE_ADC16: begin
        r16 = add16_sum[15:0];
        f.c = add16_sum[16];
        f.n = 1'b0;
        f.h = add16_low[12];
        if (mode == MODE_ADC16) begin
          f.pv = (item.wide_dest[15] ^ r16[15]) & (item.wide_source[15] ^ r16[15]);
          f.z  = (r16 == 16'd0);
          f.s  = r16[15];
        end
      end
      MODE_SBC16: begin
        r16  = sbc16_diff[15:0];
        f.c  = sbc16_diff[16];
        f.n  = 1'b1;
        f.h  = sbc16_low[12];
        f.pv = (item.wide_dest[15] ^ item.wide_source[15]) & (item.wide_dest[15] ^ r16[15]);
        f.z  = (r16 == 16'd0);
        f.s  = r16[15];
      end
      default: begin
        r16 = 16'd0;
      end
    endcase
  end

  assign outcome.result      = r16;
  assign outcome.accumulator = acc_next;
  assign outcome.flags       = f;

endmodule
